// File: hw/rtl/qau_pkg.sv
// Shared types, constants and helpers of the quaternion arithmetic unit.
// No dependencies; every other file of the unit refers to this package.
package qau_pkg;

  // default number of fraction bits (Q16.16)
  localparam int FRAC_BITS_DEF = 16;

  // width of the sums of floored products, enough for every fraction width
  localparam int SUM_W = 72;

  // operation codes
  localparam logic [2:0] CMD_MUL   = 3'd0;
  localparam logic [2:0] CMD_ROT   = 3'd1;
  localparam logic [2:0] CMD_ADD   = 3'd2;
  localparam logic [2:0] CMD_CONJ  = 3'd3;
  localparam logic [2:0] CMD_INV   = 3'd4;
  localparam logic [2:0] CMD_DOT   = 3'd5;
  localparam logic [2:0] CMD_SCALE = 3'd6;

  typedef logic signed [SUM_W-1:0] wide_t;

  // input beat
  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] a_w;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] b_w;
    logic signed [31:0] scalar;
  } in_beat_t;

  // result beat
  typedef struct packed {
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_z;
    logic signed [31:0] r_w;
    logic               saturated;
    logic               zero_length;
  } res_beat_t;

  // clipped value plus clip flag
  typedef struct packed {
    logic signed [31:0] v;
    logic               f;
  } sat_t;

  // clip a wide value to the signed 32-bit range
  function automatic sat_t sat32(input wide_t x);
    sat_t s;
    if (x > wide_t'(32'sh7fffffff)) begin
      s.v = 32'sh7fffffff;
      s.f = 1'b1;
    end else if (x < wide_t'(-32'sh7fffffff - 32'sd1)) begin
      s.v = 32'sh80000000;
      s.f = 1'b1;
    end else begin
      s.v = x[31:0];
      s.f = 1'b0;
    end
    return s;
  endfunction

endpackage

// File: hw/rtl/quaternion_arithmetic_unit_top.sv
// Top level of the quaternion arithmetic unit: front end, rotation back end,
// inverse divider, alignment delay and output register. Depends on qau_pkg.
//
// Usage:
//   Drive operands and raise start; a beat is taken at each rising edge with
//   start high and busy low. busy stays low, so a beat may enter every cycle.
//   Each beat yields one result beat on result, marked by done for exactly
//   one cycle, in the order taken. The receiver cannot hold results off.
//   Throughput is one beat per cycle. The latency is set by the inverse
//   divider, which takes one quotient bit per stage over 32 + FRAC_BITS
//   stages; all other operations are delayed to match it.
//   Reset (rst, synchronous) clears every valid bit in flight; beats in the
//   pipeline at reset are dropped and produce no result.
module quaternion_arithmetic_unit_top #(
  parameter int FRAC_BITS = qau_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  qau_pkg::in_beat_t    operands,
  output logic                 done,
  output qau_pkg::res_beat_t   result
);

  localparam int LW  = 65 - FRAC_BITS;
  localparam int NW  = 32 + FRAC_BITS;
  localparam int DLY = NW - 2;
  localparam int LAT = NW + 5;

  logic accept;
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  logic               valid3;
  logic [2:0]         cmd3;
  qau_pkg::res_beat_t res3;
  logic [3:0][31:0]   a3;
  logic [2:0][31:0]   b3;
  logic [LW-1:0]      len3;

  qau_front #(.FRAC_BITS(FRAC_BITS), .LW(LW)) u_front (
    .clk(clk), .rst(rst), .accept(accept), .operands(operands),
    .valid3(valid3), .cmd3(cmd3), .res3(res3), .a3(a3), .b3(b3), .len3(len3)
  );

  logic               valid6;
  logic [2:0]         cmd6;
  qau_pkg::res_beat_t res6;

  qau_rotate #(.FRAC_BITS(FRAC_BITS)) u_rotate (
    .clk(clk), .rst(rst), .valid3(valid3), .cmd3(cmd3), .res3(res3),
    .a3(a3), .b3(b3), .valid6(valid6), .cmd6(cmd6), .res6(res6)
  );

  logic [3:0][31:0] quot;
  logic             quot_sat;

  qau_div #(.FRAC_BITS(FRAC_BITS), .LW(LW), .NW(NW)) u_div (
    .clk(clk), .a(a3), .len(len3), .quot(quot), .quot_sat(quot_sat)
  );

  // delay line aligning the other operations with the divider
  logic               dl_v   [DLY];
  logic [2:0]         dl_cmd [DLY];
  qau_pkg::res_beat_t dl_res [DLY];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DLY; k++) begin
        dl_v[k] <= 1'b0;
      end
    end else begin
      dl_v[0] <= valid6;
      for (int k = 1; k < DLY; k++) begin
        dl_v[k] <= dl_v[k-1];
      end
    end
    dl_cmd[0] <= cmd6;
    dl_res[0] <= res6;
    for (int k = 1; k < DLY; k++) begin
      dl_cmd[k] <= dl_cmd[k-1];
      dl_res[k] <= dl_res[k-1];
    end
  end

  // output register: pick the divider result for a nonzero inverse
  qau_pkg::res_beat_t result_next;

  always_comb begin
    result_next = dl_res[DLY-1];
    if (dl_cmd[DLY-1] == qau_pkg::CMD_INV && !dl_res[DLY-1].zero_length) begin
      result_next.r_x       = quot[0];
      result_next.r_y       = quot[1];
      result_next.r_z       = quot[2];
      result_next.r_w       = quot[3];
      result_next.saturated = quot_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dl_v[DLY-1];
    end
    result <= result_next;
  end

  // every accepted beat comes out after the fixed latency
  assert property (@(posedge clk) disable iff (rst) accept |-> ##LAT done)
    else $error("accepted beat did not produce a result on time");

  // a zero-length inverse gives zeros and never the clip flag
  assert property (@(posedge clk) disable iff (rst)
    (done && result.zero_length) |->
      (!result.saturated && result.r_x == '0 && result.r_y == '0 &&
       result.r_z == '0 && result.r_w == '0))
    else $error("zero-length result carries data or clip flag");

  // no result appears without a beat taken earlier
  assert property (@(posedge clk) disable iff (rst)
    (done && !$past(rst, LAT)) |-> $past(accept, LAT))
    else $error("result without a matching accepted beat");

endmodule

// File: hw/rtl/qau_front.sv
// Front end: input register, 16 product multipliers, first sums and clipping.
// Depends on qau_pkg.
module qau_front #(
  parameter int FRAC_BITS = qau_pkg::FRAC_BITS_DEF,
  parameter int LW        = 65 - FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  qau_pkg::in_beat_t    operands,
  output logic                 valid3,
  output logic [2:0]           cmd3,
  output qau_pkg::res_beat_t   res3,
  output logic [3:0][31:0]     a3,
  output logic [2:0][31:0]     b3,
  output logic [LW-1:0]        len3
);

  localparam int PW = 64 - FRAC_BITS;

  // stage 1: input register
  logic              v1;
  qau_pkg::in_beat_t op1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
    op1 <= operands;
  end

  // stage 2: products a_i * m_j, floored
  logic signed [31:0] av [4];
  logic signed [31:0] bv [4];
  logic signed [31:0] mv [4];
  logic signed [63:0] full [4][4];

  always_comb begin
    av[0] = op1.a_x; av[1] = op1.a_y; av[2] = op1.a_z; av[3] = op1.a_w;
    bv[0] = op1.b_x; bv[1] = op1.b_y; bv[2] = op1.b_z; bv[3] = op1.b_w;
    for (int j = 0; j < 4; j++) begin
      if (op1.command == qau_pkg::CMD_INV) begin
        mv[j] = av[j];
      end else if (op1.command == qau_pkg::CMD_SCALE) begin
        mv[j] = op1.scalar;
      end else begin
        mv[j] = bv[j];
      end
    end
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        full[i][j] = 64'(av[i]) * 64'(mv[j]);
      end
    end
  end

  logic              v2;
  logic [2:0]        cmd2;
  logic signed [31:0] a2 [4];
  logic signed [31:0] b2 [4];
  logic signed [PW-1:0] prod2 [4][4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    cmd2 <= op1.command;
    for (int i = 0; i < 4; i++) begin
      a2[i] <= av[i];
      b2[i] <= bv[i];
      for (int j = 0; j < 4; j++) begin
        prod2[i][j] <= full[i][j][63:FRAC_BITS];
      end
    end
  end

  // stage 3: sums, clipping, length squared or dot product
  qau_pkg::wide_t pw [4][4];
  qau_pkg::wide_t len;
  qau_pkg::sat_t  t [4];
  logic           zl;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        pw[i][j] = qau_pkg::wide_t'(prod2[i][j]);
      end
      t[i] = '0;
    end
    len = pw[0][0] + pw[1][1] + pw[2][2] + pw[3][3];
    zl  = 1'b0;
    unique case (cmd2)
      qau_pkg::CMD_MUL: begin
        t[0] = qau_pkg::sat32(pw[0][3] + pw[1][2] - pw[2][1] + pw[3][0]);
        t[1] = qau_pkg::sat32(-pw[0][2] + pw[1][3] + pw[2][0] + pw[3][1]);
        t[2] = qau_pkg::sat32(pw[0][1] - pw[1][0] + pw[2][3] + pw[3][2]);
        t[3] = qau_pkg::sat32(-pw[0][0] - pw[1][1] - pw[2][2] + pw[3][3]);
      end
      qau_pkg::CMD_ROT: begin
        t[0] = qau_pkg::sat32(pw[1][2] - pw[2][1]);
        t[1] = qau_pkg::sat32(pw[2][0] - pw[0][2]);
        t[2] = qau_pkg::sat32(pw[0][1] - pw[1][0]);
      end
      qau_pkg::CMD_ADD: begin
        for (int i = 0; i < 4; i++) begin
          t[i] = qau_pkg::sat32(qau_pkg::wide_t'(a2[i]) + qau_pkg::wide_t'(b2[i]));
        end
      end
      qau_pkg::CMD_CONJ: begin
        for (int i = 0; i < 3; i++) begin
          t[i] = qau_pkg::sat32(-qau_pkg::wide_t'(a2[i]));
        end
        t[3].v = a2[3];
      end
      qau_pkg::CMD_INV: begin
        zl = (len == '0);
      end
      qau_pkg::CMD_DOT: begin
        t[0] = qau_pkg::sat32(len);
      end
      qau_pkg::CMD_SCALE: begin
        for (int i = 0; i < 4; i++) begin
          t[i] = qau_pkg::sat32(pw[i][0]);
        end
      end
      default: begin
        zl = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid3 <= 1'b0;
    end else begin
      valid3 <= v2;
    end
    cmd3             <= cmd2;
    res3.r_x         <= t[0].v;
    res3.r_y         <= t[1].v;
    res3.r_z         <= t[2].v;
    res3.r_w         <= t[3].v;
    res3.saturated   <= t[0].f | t[1].f | t[2].f | t[3].f;
    res3.zero_length <= zl;
    for (int i = 0; i < 4; i++) begin
      a3[i] <= a2[i];
    end
    for (int i = 0; i < 3; i++) begin
      b3[i] <= b2[i];
    end
    len3 <= len[LW-1:0];
  end

endmodule

// File: hw/rtl/qau_rotate.sv
// Rotation back end: second cross product, w scaling and final sum.
// Non-rotate results pass through unchanged. Depends on qau_pkg.
module qau_rotate #(
  parameter int FRAC_BITS = qau_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 valid3,
  input  logic [2:0]           cmd3,
  input  qau_pkg::res_beat_t   res3,
  input  logic [3:0][31:0]     a3,
  input  logic [2:0][31:0]     b3,
  output logic                 valid6,
  output logic [2:0]           cmd6,
  output qau_pkg::res_beat_t   res6
);

  localparam int PW = 64 - FRAC_BITS;

  // stage 4: nine products
  logic signed [31:0] ua [4];
  logic signed [31:0] uv [3];
  logic signed [63:0] cp [6];
  logic signed [63:0] wp [3];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ua[i] = signed'(a3[i]);
    end
    uv[0] = res3.r_x; uv[1] = res3.r_y; uv[2] = res3.r_z;
    cp[0] = 64'(ua[1]) * 64'(uv[2]);
    cp[1] = 64'(ua[2]) * 64'(uv[1]);
    cp[2] = 64'(ua[2]) * 64'(uv[0]);
    cp[3] = 64'(ua[0]) * 64'(uv[2]);
    cp[4] = 64'(ua[0]) * 64'(uv[1]);
    cp[5] = 64'(ua[1]) * 64'(uv[0]);
    for (int i = 0; i < 3; i++) begin
      wp[i] = 64'(uv[i]) * 64'(ua[3]);
    end
  end

  logic                 v4;
  logic [2:0]           cmd4;
  qau_pkg::res_beat_t   res4;
  logic [2:0][31:0]     b4;
  logic signed [PW-1:0] cp4 [6];
  logic signed [PW:0]   wp4 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= valid3;
    end
    cmd4 <= cmd3;
    res4 <= res3;
    b4   <= b3;
    for (int i = 0; i < 6; i++) begin
      cp4[i] <= cp[i][63:FRAC_BITS];
    end
    for (int i = 0; i < 3; i++) begin
      wp4[i] <= wp[i][63:FRAC_BITS-1];
    end
  end

  // stage 5: clipped second cross product
  qau_pkg::sat_t uu [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      uu[i] = qau_pkg::sat32(qau_pkg::wide_t'(cp4[2*i]) - qau_pkg::wide_t'(cp4[2*i+1]));
    end
  end

  logic                 v5;
  logic [2:0]           cmd5;
  qau_pkg::res_beat_t   res5;
  logic [2:0][31:0]     b5;
  logic signed [31:0]   uu5 [3];
  logic                 uuf5;
  logic signed [PW:0]   wp5 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
    cmd5 <= cmd4;
    res5 <= res4;
    b5   <= b4;
    uuf5 <= uu[0].f | uu[1].f | uu[2].f;
    for (int i = 0; i < 3; i++) begin
      uu5[i] <= uu[i].v;
      wp5[i] <= wp4[i];
    end
  end

  // stage 6: v + 2w(u x v) + 2 u x (u x v)
  qau_pkg::sat_t      rr [3];
  qau_pkg::res_beat_t res_next;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rr[i] = qau_pkg::sat32(qau_pkg::wide_t'(signed'(b5[i])) + qau_pkg::wide_t'(wp5[i])
                             + (qau_pkg::wide_t'(uu5[i]) <<< 1));
    end
    res_next = res5;
    if (cmd5 == qau_pkg::CMD_ROT) begin
      res_next.r_x       = rr[0].v;
      res_next.r_y       = rr[1].v;
      res_next.r_z       = rr[2].v;
      res_next.r_w       = '0;
      res_next.saturated = res5.saturated | uuf5 | rr[0].f | rr[1].f | rr[2].f;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid6 <= 1'b0;
    end else begin
      valid6 <= v5;
    end
    cmd6 <= cmd5;
    res6 <= res_next;
  end

endmodule

// File: hw/rtl/qau_div.sv
// Pipelined restoring divider, four lanes, one quotient bit per stage.
// Computes the clipped floored inverse components. Depends on qau_pkg.
module qau_div #(
  parameter int FRAC_BITS = qau_pkg::FRAC_BITS_DEF,
  parameter int LW        = 65 - FRAC_BITS,
  parameter int NW        = 32 + FRAC_BITS
) (
  input  logic                 clk,
  input  logic [3:0][31:0]     a,
  input  logic [LW-1:0]        len,
  output logic [3:0][31:0]     quot,
  output logic                 quot_sat
);

  // one restoring step: returns {next remainder, quotient bit}
  function automatic logic [LW:0] step(input logic [LW-1:0] rem, input logic nb,
                                       input logic [LW-1:0] d);
    logic [LW:0] t;
    logic [LW:0] diff;
    t    = {rem, nb};
    diff = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      return {diff[LW-1:0], 1'b1};
    end
    return {t[LW-1:0], 1'b0};
  endfunction

  // operand magnitude, adjusted so floor of a negative quotient is ~q
  logic [31:0]   mag [4];
  logic          neg0 [4];
  logic [NW-1:0] num0 [4];
  logic [NW-1:0] shl [4];

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      mag[l]  = a[l][31] ? 32'(-a[l]) : a[l];
      neg0[l] = (l < 3) ? (!a[l][31] && (a[l] != '0)) : a[l][31];
      shl[l]  = {mag[l], {FRAC_BITS{1'b0}}};
      num0[l] = neg0[l] ? shl[l] - NW'(1) : shl[l];
    end
  end

  logic [LW-1:0] rem [NW][4];
  logic [NW-1:0] num [NW][4];
  logic [NW-1:0] qq  [NW][4];
  logic          neg [NW][4];
  logic [LW-1:0] dd  [NW];
  logic [LW:0]   st  [NW][4];

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      st[0][l] = step('0, num0[l][NW-1], len);
      for (int k = 1; k < NW; k++) begin
        st[k][l] = step(rem[k-1][l], num[k-1][l][NW-1], dd[k-1]);
      end
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    dd[0] <= len;
    for (int l = 0; l < 4; l++) begin
      rem[0][l] <= st[0][l][LW:1];
      num[0][l] <= num0[l] << 1;
      qq[0][l]  <= NW'(st[0][l][0]);
      neg[0][l] <= neg0[l];
    end
    for (int k = 1; k < NW; k++) begin
      dd[k] <= dd[k-1];
      for (int l = 0; l < 4; l++) begin
        rem[k][l] <= st[k][l][LW:1];
        num[k][l] <= num[k-1][l] << 1;
        qq[k][l]  <= {qq[k-1][l][NW-2:0], st[k][l][0]};
        neg[k][l] <= neg[k-1][l];
      end
    end
  end

  // sign restore and clip
  logic        big [4];
  logic [31:0] qv  [4];

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      big[l] = |qq[NW-1][l][NW-1:31];
      if (neg[NW-1][l]) begin
        qv[l] = big[l] ? 32'h80000000 : ~qq[NW-1][l][31:0];
      end else begin
        qv[l] = big[l] ? 32'h7fffffff : qq[NW-1][l][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 4; l++) begin
      quot[l] <= qv[l];
    end
    quot_sat <= big[0] | big[1] | big[2] | big[3];
  end

endmodule
